[design/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[design/u8d_pkg.sv]
// Types and constants of the UTF-8 stream decoder
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned OUT_W   = 32;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_STRAY = 2'd1;
    localparam logic [STAT_W-1:0] ST_TRUNC = 2'd2;

    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'h3f;
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'h1f;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'h0f;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'h07;

    typedef struct packed {
        logic [LEN_W-1:0]  seq_length;
        logic [STAT_W-1:0] status;
        logic [CP_W-1:0]   code_point;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_step;

endpackage

`default_nettype wire

[design/utf8_stream_decoder_core.sv]
// A byte taken on the slave side is held in the input register and decoded there; its
// result, if any, enters the result buffer once that has room and is then shown on the master side.
// Throughput: one byte per cycle while the result buffer has room; lead and nonzero inner bytes give no result.
// The two-entry result buffer lets bytes keep flowing while one result waits.
// Reset: synchronous, active low; clears the open sequence and both stages.
// Top level of the UTF-8 stream decoder
`default_nettype none

module utf8_stream_decoder_core import u8d_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata    // [20:0] code_point, [22:21] status,
                                          // [25:23] seq_length, [31:26] zero
);

    logic              room;
    logic              fire;
    logic [BYTE_W-1:0] cur_byte;
    t_step             step;
    t_result           head;

    u8d_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_room  (room),
        .o_fire  (fire),
        .o_byte  (cur_byte)
    );

    u8d_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (cur_byte),
        .o_step  (step)
    );

    u8d_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && step.valid),
        .i_res   (step.res),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (head)
    );

    assign o_m_tdata = {{(OUT_W-CP_W-STAT_W-LEN_W){1'b0}},
                        head.seq_length, head.status, head.code_point};

endmodule

`default_nettype wire

[design/u8d_in_reg.sv]
// Input register stage for the raw byte stream
`default_nettype none

module u8d_in_reg import u8d_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_room,
    output logic                   o_fire,
    output logic [BYTE_W-1:0]      o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_fire  = r_valid && i_room;
    assign o_ready = !r_valid || o_fire;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

[design/u8d_decode.sv]
// Sequence state and one-byte decode step
`default_nettype none

module u8d_decode import u8d_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_step                  o_step
);

    logic [1:0]      r_remain, n_remain;
    logic [CP_W-1:0] r_partial, n_partial;
    logic [LEN_W-1:0] r_total, n_total;
    logic [CP_W-1:0] shifted;

    assign shifted = {r_partial[CP_W-7:0], i_byte[5:0] & MASK_CONT[5:0]};

    always_comb begin
        n_remain  = r_remain;
        n_partial = r_partial;
        n_total   = r_total;
        o_step    = '0;
        if (r_remain == 2'd0) begin
            if (i_byte inside {[8'h00:8'h7f]}) begin
                o_step.valid          = 1'b1;
                o_step.res.code_point = {{(CP_W-BYTE_W){1'b0}}, i_byte};
                o_step.res.status     = ST_OK;
                o_step.res.seq_length = 3'd1;
            end else if (i_byte inside {[8'h80:8'hbf]}) begin
                o_step.valid          = 1'b1;
                o_step.res.status     = ST_STRAY;
                o_step.res.seq_length = 3'd1;
            end else if (i_byte inside {[8'hc0:8'hdf]}) begin
                n_partial = {{(CP_W-BYTE_W){1'b0}}, i_byte & MASK_LEAD2};
                n_remain  = 2'd1;
                n_total   = 3'd2;
            end else if (i_byte inside {[8'he0:8'hef]}) begin
                n_partial = {{(CP_W-BYTE_W){1'b0}}, i_byte & MASK_LEAD3};
                n_remain  = 2'd2;
                n_total   = 3'd3;
            end else begin
                n_partial = {{(CP_W-BYTE_W){1'b0}}, i_byte & MASK_LEAD4};
                n_remain  = 2'd3;
                n_total   = 3'd4;
            end
        end else if (i_byte == 8'h00) begin
            // zero byte cuts the open sequence short
            o_step.valid          = 1'b1;
            o_step.res.status     = ST_TRUNC;
            o_step.res.seq_length = r_total - {1'b0, r_remain} + 3'd1;
            n_remain  = 2'd0;
            n_partial = '0;
            n_total   = '0;
        end else if (r_remain == 2'd1) begin
            o_step.valid          = 1'b1;
            o_step.res.code_point = shifted;
            o_step.res.status     = ST_OK;
            o_step.res.seq_length = r_total;
            n_remain  = 2'd0;
            n_partial = '0;
            n_total   = '0;
        end else begin
            n_partial = shifted;
            n_remain  = r_remain - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain  <= 2'd0;
            r_partial <= '0;
            r_total   <= '0;
        end else if (i_fire) begin
            r_remain  <= n_remain;
            r_partial <= n_partial;
            r_total   <= n_total;
        end
    end

endmodule

`default_nettype wire

[design/u8d_out_buf.sv]
// Two-entry result buffer that drives the master side
`default_nettype none

module u8d_out_buf import u8d_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic [1:0] r_count, n_count;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic       pop;

    assign o_room  = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_res   = r_slot0;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_count = r_count + {1'b0, i_push} - {1'b0, pop};
        // advance the second entry to the head when the head drains
        if (pop && r_count == 2'd2) begin
            n_slot0 = r_slot1;
        end else if (i_push && (r_count == 2'd0 || (r_count == 2'd1 && pop))) begin
            n_slot0 = i_res;
        end
        if (i_push && r_count == 2'd1 && !pop) begin
            n_slot1 = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

`default_nettype wire

[design/u8d_checker.sv]
// Port-level checker for the UTF-8 stream decoder, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module u8d_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [7:0]  i_s_tdata,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);

    `ASSERT_CLK(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")
    `ASSERT_CLK(a_err_zero, o_m_tvalid && o_m_tdata[22:21] != 2'd0 |-> o_m_tdata[20:0] == 21'd0, "error result with nonzero code point")
    `ASSERT_CLK(a_stray_len, o_m_tvalid && o_m_tdata[22:21] == 2'd1 |-> o_m_tdata[25:23] == 3'd1, "stray byte with length other than one")
    `ASSERT_CLK_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_tvalid, "result shown right after reset")

endmodule

bind utf8_stream_decoder_core u8d_checker u_chk (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the UTF-8 stream decoder core
`timescale 1ns / 100ps

module testbench;
    import u8d_pkg::*;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] data_byte
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;            // [20:0] code_point, [22:21] status,
                                       // [25:23] seq_length, [31:26] zero

    // decoder state as predicted from the accepted bytes
    logic [1:0]      cont_left;
    logic [CP_W-1:0] cp_acc;
    logic [LEN_W-1:0] seq_total;

    t_result decoded_chars[$];

    int       errors      = 0;
    int       bytes_sent  = 0;
    int       burst_left  = 0;
    int       gap_max     = 4;
    t_rx_mode rx_mode     = RX_ALWAYS;
    int       rx_period   = 4;
    int       rx_busy     = 1;
    int       rx_count    = 0;

    utf8_stream_decoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        case (rx_mode)
            RX_ALWAYS: begin
                i_m_tready <= 1'b1;
            end
            RX_RANDOM: begin
                i_m_tready <= ($urandom_range(0, 99) >= rx_busy);
            end
            default: begin
                rx_count = (rx_count + 1) % rx_period;
                i_m_tready <= (rx_count >= rx_busy);
            end
        endcase
    end

    task automatic push_char(logic [CP_W-1:0] cp, logic [STAT_W-1:0] st,
                             logic [LEN_W-1:0] len);
        t_result r;
        r.code_point = cp;
        r.status     = st;
        r.seq_length = len;
        decoded_chars.push_back(r);
    endtask

    task automatic predict_decode(logic [7:0] b);
        if (cont_left == 2'd0) begin
            if (b < 8'h80) begin
                push_char(CP_W'(b), ST_OK, 3'd1);
            end else if (b < 8'hc0) begin
                push_char('0, ST_STRAY, 3'd1);
            end else if (b < 8'he0) begin
                cp_acc    = CP_W'(b & MASK_LEAD2);
                cont_left = 2'd1;
                seq_total = 3'd2;
            end else if (b < 8'hf0) begin
                cp_acc    = CP_W'(b & MASK_LEAD3);
                cont_left = 2'd2;
                seq_total = 3'd3;
            end else begin
                cp_acc    = CP_W'(b & MASK_LEAD4);
                cont_left = 2'd3;
                seq_total = 3'd4;
            end
        end else if (b == 8'h00) begin
            // zero byte cuts the open sequence short
            push_char('0, ST_TRUNC, seq_total - LEN_W'(cont_left) + 3'd1);
            cont_left = 2'd0;
            cp_acc    = '0;
            seq_total = '0;
        end else begin
            // any nonzero byte counts as a continuation
            cp_acc    = {cp_acc[CP_W-7:0], b[5:0] & MASK_CONT[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                push_char(cp_acc, ST_OK, seq_total);
                cp_acc    = '0;
                seq_total = '0;
            end
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge i_clk) i_s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        bytes_sent++;
        predict_decode(b);
    endtask

    // hold the sender until every predicted character has come out
    task automatic drain_results();
        @(negedge i_clk) i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (decoded_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_list(input logic [7:0] seq[]);
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    function automatic logic [7:0] rand_lead(int len);
        case (len)
            2:       return 8'hc0 | 8'($urandom_range(0, 31));
            3:       return 8'he0 | 8'($urandom_range(0, 15));
            default: return 8'hf0 | 8'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_random_char();
        int kind;
        int len;
        int cut;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(2, 4);
        if (kind < 40) begin
            send_byte(8'($urandom_range(0, 127)));
        end else if (kind < 80) begin
            send_byte(rand_lead(len));
            repeat (len - 1) send_byte(8'h80 | 8'($urandom_range(0, 63)));
        end else if (kind < 87) begin
            cut = $urandom_range(1, len - 1);
            send_byte(rand_lead(len));
            repeat (cut - 1) send_byte(8'h80 | 8'($urandom_range(0, 63)));
            send_byte(8'h00);
        end else if (kind < 93) begin
            send_byte(8'h80 | 8'($urandom_range(0, 63)));
        end else begin
            // lax stream: any nonzero byte inside the sequence
            send_byte(rand_lead(len));
            repeat (len - 1) send_byte(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic run_random(int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_char();
    endtask

    task automatic test_ascii();
        send_list('{8'h00, 8'h41, 8'h7f});
        drain_results();
    endtask

    task automatic test_stray();
        send_list('{8'h80, 8'hbf});
        drain_results();
    endtask

    task automatic test_two_byte();
        send_list('{8'hc2, 8'ha9, 8'hdf, 8'hbf});
        drain_results();
    endtask

    task automatic test_three_byte();
        send_list('{8'he0, 8'h80, 8'h80, 8'hef, 8'hbf, 8'hbf});
        drain_results();
    endtask

    task automatic test_four_byte_lax();
        // second sequence takes a lead and an ASCII byte as continuations
        send_list('{8'hf0, 8'h90, 8'h80, 8'h80, 8'hff, 8'hc1, 8'h41, 8'hbf});
        drain_results();
    endtask

    task automatic test_truncated();
        send_list('{8'hf4, 8'h8f, 8'h00});
        drain_results();
    endtask

    task automatic test_random_streaming();
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        run_random(150);
        drain_results();
    endtask

    task automatic test_random_backpressure();
        gap_max   = 2;
        rx_mode   = RX_PERIODIC;
        rx_period = 9;
        rx_busy   = 6;
        run_random(300);
        drain_results();
    endtask

    task automatic test_random_mixed();
        gap_max = 8;
        rx_mode = RX_RANDOM;
        rx_busy = 40;
        run_random(300);
        drain_results();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[25:0]);
            if (decoded_chars.size() == 0) begin
                $display("%0t: unexpected transfer, got cp=%h st=%0d len=%0d",
                         $time, got.code_point, got.status, got.seq_length);
                errors++;
            end else begin
                want = decoded_chars.pop_front();
                if (got.code_point !== want.code_point) begin
                    $display("%0t: code_point mismatch, expected %h, got %h",
                             $time, want.code_point, got.code_point);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.seq_length !== want.seq_length) begin
                    $display("%0t: seq_length mismatch, expected %0d, got %0d",
                             $time, want.seq_length, got.seq_length);
                    errors++;
                end
                if (o_m_tdata[31:26] !== 6'd0) begin
                    $display("%0t: padding mismatch, expected 0, got %h",
                             $time, o_m_tdata[31:26]);
                    errors++;
                end
            end
        end
    end

    initial begin
        cont_left = 2'd0;
        cp_acc    = '0;
        seq_total = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_ascii();
        test_stray();
        test_two_byte();
        test_three_byte();
        test_four_byte_lax();
        test_truncated();
        test_random_streaming();
        test_random_backpressure();
        test_random_mixed();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && decoded_chars.size() == 0) begin
            $display("[utf8_stream_decoder_core] OK");
        end else begin
            $display("[utf8_stream_decoder_core] ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[utf8_stream_decoder_core] ERROR");
        $finish;
    end

endmodule
